// ===== rtl/core/prqs_pkg.sv =====
// ----------------------------------------------------------------------------
// prqs_pkg
// shared types and constants of the priority run queue scheduler
// ----------------------------------------------------------------------------
package prqs_pkg;

  localparam int unsigned NUM_TASKS  = 64;
  localparam int unsigned NUM_LEVELS = 16;
  localparam int unsigned MAX_CPUS   = 8;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned LVL_W      = 4;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned CPU_W      = 4;
  localparam logic [CPU_W-1:0] CPU_NONE = 4'd8;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_WIRE  = 2'd2,
    OP_CHECK = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDATA,
    S_ETAIL,
    S_EWR,
    S_WDATA,
    S_LSCAN,
    S_LDATA,
    S_TCHK,
    S_DUNL,
    S_DFIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [SLOT_W-1:0] next;
    logic [CPU_W-1:0]  last;
    logic [CPU_W-1:0]  wired;
    logic              queued;
  } task_ent_t;

  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
    logic [CNT_W-1:0]  count;
  } lvl_ent_t;

endpackage

// ===== rtl/core/prqs_ram.sv =====
// ----------------------------------------------------------------------------
// prqs_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module prqs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/priority_run_queue_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// priority_run_queue_scheduler_unit
// multilevel priority run queue with linked-list task storage
// ----------------------------------------------------------------------------
// channel  dir  handshake                 payload
// s_axis   in   s_axis_tvalid/tready      tuser operation, tdata slot..tick
// m_axis   out  m_axis_tvalid/tready      tuser status, tdata slot..total
// cfg      in   cfg_valid_i/cfg_ready_o   cfg_data_i num_cpus
//
// one item at a time; enqueue stops with a duplicate status if the task is queued, else links
// behind the old tail of an occupied level and writes; dequeue scans levels upward, inspects
// tasks of occupied levels over up to two passes, then unlinks and reports, else reports none
// state sits in a task ram and a level ram, one read per cycle each
// reset clears valid bits at once, no clearing pass
// a finished result waits in the output register while the next beat enters
module priority_run_queue_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // task_slot, level, cpu_id, tick, zero pad
  input  logic [1:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // picked_slot, picked_level, preempt,
                                     // ready_total, zero pad
  output logic [1:0]  m_axis_tuser,  // status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);

  localparam int unsigned SW = prqs_pkg::SLOT_W;
  localparam int unsigned LW = prqs_pkg::LVL_W;
  localparam int unsigned CW = prqs_pkg::CNT_W;
  localparam int unsigned PW = prqs_pkg::CPU_W;
  localparam int unsigned TEW = $bits(prqs_pkg::task_ent_t);
  localparam int unsigned LEW = $bits(prqs_pkg::lvl_ent_t);

  function automatic logic [2:0] cpu_mod(input logic [2:0] c, input logic [3:0] n);
    logic [3:0] r;
    r = {1'b0, c};
    for (int i = 0; i < 8; i++) begin
      if (r >= n) begin
        r = r - n;
      end
    end
    return r[2:0];
  endfunction

  prqs_pkg::state_e state_q, state_d;

  logic [3:0]    ncpu_q;

  logic [1:0]    op_q;
  logic [SW-1:0] slot_q, slot_d;
  logic [LW-1:0] lv_q, lv_d;
  logic [2:0]    cpu_q;
  logic          pass_q, pass_d;
  logic [SW-1:0] cur_q, cur_d, prev_q, prev_d;
  logic [CW-1:0] k_q, k_d;
  logic [15:0]   occ_q, occ_d;
  logic [CW-1:0] rcnt_q, rcnt_d;
  prqs_pkg::task_ent_t ent_q, ent_d, pent_q, pent_d;
  prqs_pkg::lvl_ent_t  lvl_q, lvl_d;
  logic [1:0]    status_q, status_d;
  logic [SW-1:0] pslot_q, pslot_d;
  logic [LW-1:0] plvl_q, plvl_d;
  logic          pre_q, pre_d;

  logic          ovalid_q;
  logic [1:0]    ostat_q;
  logic [SW-1:0] oslot_q;
  logic [LW-1:0] olvl_q;
  logic          opre_q;
  logic [CW-1:0] otot_q;

  logic [prqs_pkg::NUM_TASKS-1:0]  tvb_q;
  logic [prqs_pkg::NUM_LEVELS-1:0] lvb_q;
  logic          tvld_q, lvld_q;

  logic          t_we;
  logic [SW-1:0] t_waddr, t_raddr;
  prqs_pkg::task_ent_t t_wdata, t_rraw, t_rd;
  logic          l_we;
  logic [LW-1:0] l_waddr, l_raddr;
  prqs_pkg::lvl_ent_t  l_wdata, l_rraw, l_rd;

  logic s_acc, out_free, eligible, walk_last, scan_end;
  logic [SW-1:0] in_slot;
  logic [LW-1:0] in_lv;
  logic [2:0]    in_cpu, wcpu;

  assign s_axis_tready = (state_q == prqs_pkg::S_IDLE);
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign in_slot  = s_axis_tdata[5:0];
  assign in_lv    = s_axis_tdata[9:6];
  assign in_cpu   = s_axis_tdata[12:10];
  assign out_free = !ovalid_q || m_axis_tready;
  assign cfg_ready_o = 1'b1;

  prqs_ram #(.WIDTH(TEW), .DEPTH(prqs_pkg::NUM_TASKS)) u_task_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rraw)
  );

  prqs_ram #(.WIDTH(LEW), .DEPTH(prqs_pkg::NUM_LEVELS)) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rraw)
  );

  // task entries never written read as their reset value, level entries as a zero count
  always_comb begin
    t_rd = t_rraw;
    if (!tvld_q) begin
      t_rd = '{next: '0, last: prqs_pkg::CPU_NONE, wired: prqs_pkg::CPU_NONE,
               queued: 1'b0};
    end
    l_rd = l_rraw;
    if (!lvld_q) begin
      l_rd.count = '0;
    end
  end

  assign eligible = (t_rd.last == prqs_pkg::CPU_NONE) || (t_rd.last == {1'b0, cpu_q}) ||
                    (pass_q && (t_rd.wired == prqs_pkg::CPU_NONE));
  assign walk_last = ((k_q + 1'b1) == lvl_q.count);
  assign scan_end  = pass_q && (lv_q == LW'(prqs_pkg::NUM_LEVELS - 1));
  assign wcpu      = cpu_mod(cpu_q, (ncpu_q == 4'd0) ? 4'd1 :
                             (ncpu_q > 4'(prqs_pkg::MAX_CPUS)) ?
                             4'(prqs_pkg::MAX_CPUS) : ncpu_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      prqs_pkg::S_IDLE: begin
        if (s_acc) begin
          case (prqs_pkg::op_e'(s_axis_tuser))
            prqs_pkg::OP_ENQ:  state_d = prqs_pkg::S_EDATA;
            prqs_pkg::OP_DEQ:  state_d = prqs_pkg::S_LSCAN;
            prqs_pkg::OP_WIRE: state_d = prqs_pkg::S_WDATA;
            default:           state_d = prqs_pkg::S_DONE;
          endcase
        end
      end
      prqs_pkg::S_EDATA: begin
        if (t_rd.queued) begin
          state_d = prqs_pkg::S_DONE;
        end else if (l_rd.count != '0) begin
          state_d = prqs_pkg::S_ETAIL;
        end else begin
          state_d = prqs_pkg::S_EWR;
        end
      end
      prqs_pkg::S_ETAIL: state_d = prqs_pkg::S_EWR;
      prqs_pkg::S_EWR:   state_d = prqs_pkg::S_DONE;
      prqs_pkg::S_WDATA: state_d = prqs_pkg::S_DONE;
      prqs_pkg::S_LSCAN: begin
        if (occ_q[lv_q]) begin
          state_d = prqs_pkg::S_LDATA;
        end else if (scan_end) begin
          state_d = prqs_pkg::S_DONE;
        end
      end
      prqs_pkg::S_LDATA: state_d = prqs_pkg::S_TCHK;
      prqs_pkg::S_TCHK: begin
        if (eligible) begin
          state_d = prqs_pkg::S_DUNL;
        end else if (walk_last) begin
          state_d = scan_end ? prqs_pkg::S_DONE : prqs_pkg::S_LSCAN;
        end
      end
      prqs_pkg::S_DUNL: state_d = prqs_pkg::S_DFIN;
      prqs_pkg::S_DFIN: state_d = prqs_pkg::S_DONE;
      prqs_pkg::S_DONE: begin
        if (out_free) begin
          state_d = prqs_pkg::S_IDLE;
        end
      end
      default: state_d = prqs_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    slot_d = slot_q;  lv_d = lv_q;  pass_d = pass_q;
    cur_d = cur_q;  prev_d = prev_q;  k_d = k_q;
    occ_d = occ_q;  rcnt_d = rcnt_q;
    ent_d = ent_q;  pent_d = pent_q;  lvl_d = lvl_q;
    status_d = status_q;  pslot_d = pslot_q;  plvl_d = plvl_q;  pre_d = pre_q;
    t_we = 1'b0;  t_waddr = slot_q;  t_wdata = ent_q;  t_raddr = slot_q;
    l_we = 1'b0;  l_waddr = lv_q;    l_wdata = lvl_q;  l_raddr = lv_q;
    case (state_q)
      prqs_pkg::S_IDLE: begin
        t_raddr = in_slot;
        l_raddr = in_lv;
        slot_d = in_slot;
        lv_d = (s_axis_tuser == prqs_pkg::OP_DEQ) ? '0 : in_lv;
        pass_d = 1'b0;
        status_d = prqs_pkg::ST_DONE;
        pslot_d = '0;  plvl_d = '0;
        pre_d = ((occ_q & ((16'd1 << in_lv) - 16'd1)) != '0) ||
                (s_axis_tdata[13] && occ_q[in_lv]);
      end
      prqs_pkg::S_EDATA: begin
        ent_d = t_rd;
        lvl_d = l_rd;
        t_raddr = l_rd.tail;
        if (t_rd.queued) begin
          status_d = prqs_pkg::ST_DUP;
        end
      end
      prqs_pkg::S_ETAIL: begin
        t_we = 1'b1;
        t_waddr = lvl_q.tail;
        t_wdata = t_rd;
        t_wdata.next = slot_q;
      end
      prqs_pkg::S_EWR: begin
        t_we = 1'b1;
        t_wdata = ent_q;
        t_wdata.next = '0;
        t_wdata.queued = 1'b1;
        l_we = 1'b1;
        l_wdata.head = (lvl_q.count == '0) ? slot_q : lvl_q.head;
        l_wdata.tail = slot_q;
        l_wdata.count = lvl_q.count + 1'b1;
        rcnt_d = rcnt_q + 1'b1;
        occ_d[lv_q] = 1'b1;
      end
      prqs_pkg::S_WDATA: begin
        t_we = 1'b1;
        t_wdata = t_rd;
        t_wdata.wired = {1'b0, wcpu};
        t_wdata.last = {1'b0, wcpu};
      end
      prqs_pkg::S_LSCAN: begin
        if (!occ_q[lv_q]) begin
          if (scan_end) begin
            status_d = prqs_pkg::ST_NONE;
          end else if (lv_q == LW'(prqs_pkg::NUM_LEVELS - 1)) begin
            pass_d = 1'b1;
            lv_d = '0;
          end else begin
            lv_d = lv_q + 1'b1;
          end
        end
      end
      prqs_pkg::S_LDATA: begin
        lvl_d = l_rd;
        cur_d = l_rd.head;
        k_d = '0;
        t_raddr = l_rd.head;
      end
      prqs_pkg::S_TCHK: begin
        t_raddr = t_rd.next;
        if (eligible) begin
          ent_d = t_rd;
        end else if (walk_last) begin
          if (scan_end) begin
            status_d = prqs_pkg::ST_NONE;
          end else if (lv_q == LW'(prqs_pkg::NUM_LEVELS - 1)) begin
            pass_d = 1'b1;
            lv_d = '0;
          end else begin
            lv_d = lv_q + 1'b1;
          end
        end else begin
          prev_d = cur_q;
          pent_d = t_rd;
          cur_d = t_rd.next;
          k_d = k_q + 1'b1;
        end
      end
      prqs_pkg::S_DUNL: begin
        t_we = (k_q != '0);
        t_waddr = prev_q;
        t_wdata = pent_q;
        t_wdata.next = ent_q.next;
        l_we = 1'b1;
        l_wdata.head = (k_q != '0) ? lvl_q.head : ent_q.next;
        l_wdata.tail = (lvl_q.tail == cur_q) ? prev_q : lvl_q.tail;
        l_wdata.count = lvl_q.count - 1'b1;
        if (lvl_q.count == CW'(1)) begin
          occ_d[lv_q] = 1'b0;
        end
        rcnt_d = rcnt_q - 1'b1;
      end
      prqs_pkg::S_DFIN: begin
        t_we = 1'b1;
        t_waddr = cur_q;
        t_wdata = ent_q;
        t_wdata.queued = 1'b0;
        t_wdata.last = {1'b0, cpu_q};
        pslot_d = cur_q;
        plvl_d = lv_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= prqs_pkg::S_IDLE;
      ncpu_q   <= 4'd1;
      occ_q    <= '0;
      rcnt_q   <= '0;
      tvb_q    <= '0;
      lvb_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      rcnt_q  <= rcnt_d;
      if (cfg_valid_i) begin
        ncpu_q <= cfg_data_i;
      end
      if (t_we) begin
        tvb_q[t_waddr] <= 1'b1;
      end
      if (l_we) begin
        lvb_q[l_waddr] <= 1'b1;
      end
      if (state_q == prqs_pkg::S_DONE && out_free) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;  lv_q <= lv_d;  pass_q <= pass_d;
    cur_q <= cur_d;  prev_q <= prev_d;  k_q <= k_d;
    ent_q <= ent_d;  pent_q <= pent_d;  lvl_q <= lvl_d;
    status_q <= status_d;  pslot_q <= pslot_d;  plvl_q <= plvl_d;  pre_q <= pre_d;
    tvld_q <= tvb_q[t_raddr];
    lvld_q <= lvb_q[l_raddr];
    if (s_acc) begin
      op_q   <= s_axis_tuser;
      cpu_q  <= in_cpu;
    end
    if (state_q == prqs_pkg::S_DONE && out_free) begin
      ostat_q <= status_q;
      oslot_q <= pslot_q;
      olvl_q  <= plvl_q;
      opre_q  <= (op_q == prqs_pkg::OP_CHECK) ? pre_q : 1'b0;
      otot_q  <= rcnt_q;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tdata  = {6'd0, otot_q, opre_q, olvl_q, oslot_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= CW'(prqs_pkg::NUM_TASKS))
    else $error("ready count above task count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) == (rcnt_q == '0))
    else $error("occupancy map disagrees with ready count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("second beat taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == prqs_pkg::ST_NONE) |->
    (m_axis_tdata[9:0] == '0))
    else $error("picked fields set on empty dequeue");

endmodule
